@@ rtl/fusc_pkg.sv @@
`timescale 1ns / 1ps

package fusc_pkg;

  localparam logic [31:0] MaxImageSizeReset = 32'd262144;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_IGNORE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_FLASH    = 3'd2,
    ST_STATE    = 3'd3,
    ST_SEQUENCE = 3'd4,
    ST_SIZE     = 3'd5,
    ST_CRC      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    LED_KEEP     = 2'd0,
    LED_ERROR    = 2'd1,
    LED_SUCCESS  = 2'd2,
    LED_DOWNLOAD = 2'd3
  } led_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        ack_wanted;
    logic        has_notifier;
    logic [31:0] image_size;
    logic [15:0] chunk_sequence;
    logic [15:0] chunk_length;
    logic [31:0] announced_crc;
    logic [31:0] image_crc;
    logic        erase_ok;
    logic        write_ok;
    logic        commit_ok;
  } cmd_t;

  typedef struct packed {
    kind_t       reply_kind;
    status_t     status;
    logic [15:0] reply_sequence;
    logic        send_ack;
    logic        notify;
    led_t        led_state;
    logic        do_erase;
    logic        do_write;
    logic        do_commit;
    logic        request_reset;
  } reply_t;

endpackage

@@ rtl/fusc_session.sv @@
`timescale 1ns / 1ps

module fusc_session (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  fusc_pkg::cmd_t     cmd,
  input  logic [31:0]        max_image_size,
  output logic               has_result,
  output fusc_pkg::reply_t   result
);

  logic        session_open;
  logic        session_open_next;
  logic [15:0] next_sequence;
  logic [15:0] next_sequence_next;
  logic [31:0] target_size;
  logic [31:0] target_size_next;
  logic [31:0] bytes_received;
  logic [31:0] bytes_received_next;

  logic [32:0] byte_sum;
  logic [15:0] prev_sequence;
  logic        direct;
  fusc_pkg::status_t st;

  assign byte_sum      = {1'b0, bytes_received} + {17'b0, cmd.chunk_length};
  assign prev_sequence = next_sequence - 16'd1;

  always_comb begin
    session_open_next   = session_open;
    next_sequence_next  = next_sequence;
    target_size_next    = target_size;
    bytes_received_next = bytes_received;
    st                  = fusc_pkg::ST_OK;
    direct              = 1'b0;
    has_result          = 1'b1;
    result              = '0;
    result.reply_kind   = fusc_pkg::KIND_START;

    unique case (cmd.opcode)
      fusc_pkg::OP_START: begin
        result.reply_kind = fusc_pkg::KIND_START;
        result.reply_sequence = 16'd0;
        priority if (cmd.image_size == 32'd0 || cmd.image_size > max_image_size) begin
          session_open_next = 1'b0;
          st = fusc_pkg::ST_LENGTH;
        end else if (!cmd.erase_ok) begin
          session_open_next = 1'b0;
          st = fusc_pkg::ST_FLASH;
          result.do_erase = 1'b1;
        end else begin
          target_size_next    = cmd.image_size;
          bytes_received_next = 32'd0;
          next_sequence_next  = 16'd0;
          session_open_next   = 1'b1;
          result.do_erase     = 1'b1;
        end
      end
      fusc_pkg::OP_DATA: begin
        result.reply_kind = fusc_pkg::KIND_DATA;
        result.reply_sequence = cmd.chunk_sequence;
        priority if (!session_open) begin
          st = fusc_pkg::ST_STATE;
        end else if (cmd.ack_wanted && cmd.chunk_length == 16'd0) begin
          direct = 1'b1;
          st = fusc_pkg::ST_LENGTH;
        end else if (cmd.ack_wanted && next_sequence != 16'd0 &&
                     cmd.chunk_sequence == prev_sequence) begin
          // duplicate chunk: re-acknowledge, write nothing
          direct = 1'b1;
        end else if (cmd.ack_wanted && cmd.chunk_sequence != next_sequence) begin
          direct = 1'b1;
          st = fusc_pkg::ST_SEQUENCE;
        end else if (cmd.chunk_length == 16'd0 || byte_sum > {1'b0, target_size}) begin
          st = fusc_pkg::ST_LENGTH;
        end else if (!cmd.write_ok) begin
          st = fusc_pkg::ST_FLASH;
          result.do_write = 1'b1;
        end else begin
          bytes_received_next = byte_sum[31:0];
          result.do_write = 1'b1;
          if (cmd.ack_wanted) begin
            next_sequence_next = next_sequence + 16'd1;
          end
        end
      end
      fusc_pkg::OP_END: begin
        result.reply_kind = fusc_pkg::KIND_END;
        result.reply_sequence = next_sequence;
        priority if (!session_open) begin
          st = fusc_pkg::ST_STATE;
        end else if (bytes_received != target_size || cmd.image_size != target_size) begin
          st = fusc_pkg::ST_SIZE;
        end else if (cmd.announced_crc != cmd.image_crc) begin
          st = fusc_pkg::ST_CRC;
        end else if (!cmd.commit_ok) begin
          st = fusc_pkg::ST_FLASH;
          result.do_commit = 1'b1;
        end else begin
          session_open_next = 1'b0;
          result.do_commit = 1'b1;
          result.request_reset = 1'b1;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase

    result.status = st;
    if (direct) begin
      result.send_ack  = 1'b1;
      result.notify    = 1'b0;
      result.led_state = (st != fusc_pkg::ST_OK) ? fusc_pkg::LED_ERROR : fusc_pkg::LED_KEEP;
    end else begin
      result.send_ack = cmd.ack_wanted;
      result.notify   = cmd.has_notifier;
      priority if (st != fusc_pkg::ST_OK) begin
        result.led_state = fusc_pkg::LED_ERROR;
      end else if (result.reply_kind == fusc_pkg::KIND_END) begin
        result.led_state = fusc_pkg::LED_SUCCESS;
      end else begin
        result.led_state = fusc_pkg::LED_DOWNLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_open   <= 1'b0;
      next_sequence  <= 16'd0;
      target_size    <= 32'd0;
      bytes_received <= 32'd0;
    end else if (go) begin
      session_open   <= session_open_next;
      next_sequence  <= next_sequence_next;
      target_size    <= target_size_next;
      bytes_received <= bytes_received_next;
    end
  end

endmodule

@@ rtl/fusc_out_reg.sv @@
`timescale 1ns / 1ps

module fusc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fusc_pkg::reply_t result_in,
  input  logic             out_stall,
  output logic             free,
  output logic             out_valid,
  output fusc_pkg::reply_t result
);

  // free when empty or the held beat leaves this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

@@ rtl/firmware_update_session_checker_top.sv @@
`timescale 1ns / 1ps
// firmware update session checker
// input channel: in_valid / in_stall with one command per beat (start, data chunk,
//   end; opcode 3 is dropped without a reply). flash outcomes and the image crc
//   travel with the command.
// output channel: out_valid / out_stall, one reply beat per start, data or end.
// config channel: cfg_valid / cfg_ready / cfg_data writes max_image_size; ready is
//   always high, write it only while no command is in flight.
// path: an accepted command waits in the input register, then its reply is loaded
//   into the reply register (one input register, one reply register).
// throughput: one command per cycle unless stalled; the session registers update in
//   the same cycle as the reply is registered, so back-to-back commands see fresh state.
// stall: when out_stall holds a reply, the input register waits and in_stall
//   rises for as long as it holds a command; dropped opcodes never wait.
// reset: synchronous; closes the session, clears the counters and sets
//   max_image_size to 262144 bytes.
module firmware_update_session_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic        ack_wanted,
  input  logic        has_notifier,
  input  logic [31:0] image_size,
  input  logic [15:0] chunk_sequence,
  input  logic [15:0] chunk_length,
  input  logic [31:0] announced_crc,
  input  logic [31:0] image_crc,
  input  logic        erase_ok,
  input  logic        write_ok,
  input  logic        commit_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  reply_kind,
  output logic [2:0]  status,
  output logic [15:0] reply_sequence,
  output logic        send_ack,
  output logic        notify,
  output logic [1:0]  led_state,
  output logic        do_erase,
  output logic        do_write,
  output logic        do_commit,
  output logic        request_reset
);

  logic [31:0]      max_image_size;
  logic             cmd_valid;
  fusc_pkg::cmd_t   cmd;
  fusc_pkg::cmd_t   cmd_in;
  logic             has_result;
  fusc_pkg::reply_t result_next;
  fusc_pkg::reply_t result;
  logic             out_free;
  logic             cmd_go;
  logic             in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_image_size <= fusc_pkg::MaxImageSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      max_image_size <= cfg_data;
    end
  end

  always_comb begin
    cmd_in.opcode         = fusc_pkg::opcode_t'(opcode);
    cmd_in.ack_wanted     = ack_wanted;
    cmd_in.has_notifier   = has_notifier;
    cmd_in.image_size     = image_size;
    cmd_in.chunk_sequence = chunk_sequence;
    cmd_in.chunk_length   = chunk_length;
    cmd_in.announced_crc  = announced_crc;
    cmd_in.image_crc      = image_crc;
    cmd_in.erase_ok       = erase_ok;
    cmd_in.write_ok       = write_ok;
    cmd_in.commit_ok      = commit_ok;
  end

  // a held command moves on when its reply has room, or when it makes none
  assign cmd_go   = cmd_valid && (out_free || !has_result);
  assign in_stall = cmd_valid && !cmd_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_go) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd <= cmd_in;
    end
  end

  fusc_session u_session (
    .clk            (clk),
    .rst            (rst),
    .go             (cmd_go),
    .cmd            (cmd),
    .max_image_size (max_image_size),
    .has_result     (has_result),
    .result         (result_next)
  );

  fusc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd_go && has_result),
    .result_in (result_next),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .result    (result)
  );

  assign reply_kind     = result.reply_kind;
  assign status         = result.status;
  assign reply_sequence = result.reply_sequence;
  assign send_ack       = result.send_ack;
  assign notify         = result.notify;
  assign led_state      = result.led_state;
  assign do_erase       = result.do_erase;
  assign do_write       = result.do_write;
  assign do_commit      = result.do_commit;
  assign request_reset  = result.request_reset;

  a_reset_only_on_good_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && request_reset) |->
      (status == fusc_pkg::ST_OK && reply_kind == fusc_pkg::KIND_END && do_commit))
    else $error("restart requested without a committed end");

  a_write_only_on_data : assert property (@(posedge clk) disable iff (rst)
    (out_valid && do_write) |-> (reply_kind == fusc_pkg::KIND_DATA && !do_erase && !do_commit))
    else $error("flash write flagged outside a data reply");

  a_keep_led_is_duplicate : assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_state == fusc_pkg::LED_KEEP) |->
      (send_ack && !notify && status == fusc_pkg::ST_OK && !do_write))
    else $error("unchanged led on a reply that is not a duplicate ack");

  a_held_command_waits : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_go) |=> (cmd_valid && $stable(cmd)))
    else $error("held command lost while waiting for the reply register");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 400000;
  localparam int LongHoldCycles = 80;

  // expected replies and the session state that produces them
  class session_scoreboard;
    logic [31:0] max_size;
    logic        session_open;
    logic [15:0] next_seq;
    logic [31:0] target_size;
    logic [31:0] bytes_rcvd;
    fusc_pkg::reply_t pending_replies[$];
    int          errors;

    function new();
      max_size     = fusc_pkg::MaxImageSizeReset;
      session_open = 1'b0;
      next_seq     = '0;
      target_size  = '0;
      bytes_rcvd   = '0;
      errors       = 0;
    endfunction

    function fusc_pkg::reply_t make_reply(fusc_pkg::kind_t kind, fusc_pkg::status_t st,
                                          logic [15:0] seq, logic ack, logic ntf);
      fusc_pkg::reply_t r;
      r = '0;
      r.reply_kind     = kind;
      r.status         = st;
      r.reply_sequence = seq;
      r.send_ack       = ack;
      r.notify         = ntf;
      if (st != fusc_pkg::ST_OK) begin
        r.led_state = fusc_pkg::LED_ERROR;
      end else if (kind == fusc_pkg::KIND_END) begin
        r.led_state = fusc_pkg::LED_SUCCESS;
      end else begin
        r.led_state = fusc_pkg::LED_DOWNLOAD;
      end
      return r;
    endfunction

    // bare acknowledge to the sender, requester not told, led only on error
    function fusc_pkg::reply_t ack_only(fusc_pkg::status_t st, logic [15:0] seq);
      fusc_pkg::reply_t r;
      r = make_reply(fusc_pkg::KIND_DATA, st, seq, 1'b1, 1'b0);
      if (st == fusc_pkg::ST_OK) begin
        r.led_state = fusc_pkg::LED_KEEP;
      end
      return r;
    endfunction

    function void note_command(fusc_pkg::cmd_t c);
      fusc_pkg::reply_t r;
      logic [15:0] prev_seq;
      logic [32:0] total;
      prev_seq = next_seq - 16'd1;
      total = {1'b0, bytes_rcvd} + {17'b0, c.chunk_length};
      unique case (c.opcode)
        fusc_pkg::OP_START: begin
          if (c.image_size == 32'd0 || c.image_size > max_size) begin
            session_open = 1'b0;
            r = make_reply(fusc_pkg::KIND_START, fusc_pkg::ST_LENGTH, 16'd0, c.ack_wanted,
                           c.has_notifier);
          end else if (!c.erase_ok) begin
            session_open = 1'b0;
            r = make_reply(fusc_pkg::KIND_START, fusc_pkg::ST_FLASH, 16'd0, c.ack_wanted,
                           c.has_notifier);
            r.do_erase = 1'b1;
          end else begin
            target_size  = c.image_size;
            bytes_rcvd   = '0;
            next_seq     = '0;
            session_open = 1'b1;
            r = make_reply(fusc_pkg::KIND_START, fusc_pkg::ST_OK, 16'd0, c.ack_wanted,
                           c.has_notifier);
            r.do_erase = 1'b1;
          end
        end
        fusc_pkg::OP_DATA: begin
          if (!session_open) begin
            r = make_reply(fusc_pkg::KIND_DATA, fusc_pkg::ST_STATE, c.chunk_sequence,
                           c.ack_wanted, c.has_notifier);
          end else if (c.ack_wanted && c.chunk_length == 16'd0) begin
            r = ack_only(fusc_pkg::ST_LENGTH, c.chunk_sequence);
          end else if (c.ack_wanted && next_seq != 16'd0 && c.chunk_sequence == prev_seq) begin
            r = ack_only(fusc_pkg::ST_OK, c.chunk_sequence);
          end else if (c.ack_wanted && c.chunk_sequence != next_seq) begin
            r = ack_only(fusc_pkg::ST_SEQUENCE, c.chunk_sequence);
          end else if (c.chunk_length == 16'd0 || total > {1'b0, target_size}) begin
            r = make_reply(fusc_pkg::KIND_DATA, fusc_pkg::ST_LENGTH, c.chunk_sequence,
                           c.ack_wanted, c.has_notifier);
          end else if (!c.write_ok) begin
            r = make_reply(fusc_pkg::KIND_DATA, fusc_pkg::ST_FLASH, c.chunk_sequence,
                           c.ack_wanted, c.has_notifier);
            r.do_write = 1'b1;
          end else begin
            bytes_rcvd = total[31:0];
            r = make_reply(fusc_pkg::KIND_DATA, fusc_pkg::ST_OK, c.chunk_sequence,
                           c.ack_wanted, c.has_notifier);
            r.do_write = 1'b1;
            if (c.ack_wanted) begin
              next_seq = next_seq + 16'd1;
            end
          end
        end
        fusc_pkg::OP_END: begin
          if (!session_open) begin
            r = make_reply(fusc_pkg::KIND_END, fusc_pkg::ST_STATE, next_seq, c.ack_wanted,
                           c.has_notifier);
          end else if (bytes_rcvd != target_size || c.image_size != target_size) begin
            r = make_reply(fusc_pkg::KIND_END, fusc_pkg::ST_SIZE, next_seq, c.ack_wanted,
                           c.has_notifier);
          end else if (c.announced_crc != c.image_crc) begin
            r = make_reply(fusc_pkg::KIND_END, fusc_pkg::ST_CRC, next_seq, c.ack_wanted,
                           c.has_notifier);
          end else if (!c.commit_ok) begin
            r = make_reply(fusc_pkg::KIND_END, fusc_pkg::ST_FLASH, next_seq, c.ack_wanted,
                           c.has_notifier);
            r.do_commit = 1'b1;
          end else begin
            session_open = 1'b0;
            r = make_reply(fusc_pkg::KIND_END, fusc_pkg::ST_OK, next_seq, c.ack_wanted,
                           c.has_notifier);
            r.do_commit     = 1'b1;
            r.request_reset = 1'b1;
          end
        end
        default: return;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(fusc_pkg::reply_t got);
      fusc_pkg::reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with nothing outstanding, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = pending_replies.pop_front();
      check_field("reply_kind", want.reply_kind, got.reply_kind);
      check_field("status", want.status, got.status);
      check_field("reply_sequence", want.reply_sequence, got.reply_sequence);
      check_field("send_ack", want.send_ack, got.send_ack);
      check_field("notify", want.notify, got.notify);
      check_field("led_state", want.led_state, got.led_state);
      check_field("do_erase", want.do_erase, got.do_erase);
      check_field("do_write", want.do_write, got.do_write);
      check_field("do_commit", want.do_commit, got.do_commit);
      check_field("request_reset", want.request_reset, got.request_reset);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic        ack_wanted;
  logic        has_notifier;
  logic [31:0] image_size;
  logic [15:0] chunk_sequence;
  logic [15:0] chunk_length;
  logic [31:0] announced_crc;
  logic [31:0] image_crc;
  logic        erase_ok;
  logic        write_ok;
  logic        commit_ok;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  reply_kind;
  logic [2:0]  status;
  logic [15:0] reply_sequence;
  logic        send_ack;
  logic        notify;
  logic [1:0]  led_state;
  logic        do_erase;
  logic        do_write;
  logic        do_commit;
  logic        request_reset;

  session_scoreboard sb = new();
  int cycle_count = 0;
  int commands_sent = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  bit long_hold = 1'b0;

  always #5 clk = ~clk;

  firmware_update_session_checker_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .ack_wanted     (ack_wanted),
    .has_notifier   (has_notifier),
    .image_size     (image_size),
    .chunk_sequence (chunk_sequence),
    .chunk_length   (chunk_length),
    .announced_crc  (announced_crc),
    .image_crc      (image_crc),
    .erase_ok       (erase_ok),
    .write_ok       (write_ok),
    .commit_ok      (commit_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .reply_kind     (reply_kind),
    .status         (status),
    .reply_sequence (reply_sequence),
    .send_ack       (send_ack),
    .notify         (notify),
    .led_state      (led_state),
    .do_erase       (do_erase),
    .do_write       (do_write),
    .do_commit      (do_commit),
    .request_reset  (request_reset)
  );

  // mostly back to back, often a short gap, now and then a long pause
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // reply beats are checked at the edge that accepts them
  always @(posedge clk) begin : reply_monitor
    fusc_pkg::reply_t got;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      got = {reply_kind, status, reply_sequence, send_ack, notify, led_state,
             do_erase, do_write, do_commit, request_reset};
      sb.check_reply(got);
    end
  end

  initial begin : reply_backpressure
    bit stall_now;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall_now = !quiet_out && ($urandom_range(0, 2) == 0);
        out_stall <= stall_now;
        repeat (1 + idle_length()) @(posedge clk);
      end
    end
  end

  function automatic fusc_pkg::cmd_t random_cmd();
    logic [159:0]   bits;
    fusc_pkg::cmd_t c;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    c = bits[$bits(fusc_pkg::cmd_t)-1:0];
    return c;
  endfunction

  function automatic fusc_pkg::cmd_t start_cmd(logic [31:0] size, logic eok, logic ack);
    fusc_pkg::cmd_t c;
    c = random_cmd();
    c.opcode     = fusc_pkg::OP_START;
    c.image_size = size;
    c.erase_ok   = eok;
    c.ack_wanted = ack;
    return c;
  endfunction

  function automatic fusc_pkg::cmd_t data_cmd(logic [15:0] seq, logic [15:0] len,
                                              logic wok, logic ack);
    fusc_pkg::cmd_t c;
    c = random_cmd();
    c.opcode         = fusc_pkg::OP_DATA;
    c.chunk_sequence = seq;
    c.chunk_length   = len;
    c.write_ok       = wok;
    c.ack_wanted     = ack;
    return c;
  endfunction

  function automatic fusc_pkg::cmd_t end_cmd(logic [31:0] size, logic [31:0] ecrc,
                                             logic [31:0] icrc, logic cok, logic ack);
    fusc_pkg::cmd_t c;
    c = random_cmd();
    c.opcode        = fusc_pkg::OP_END;
    c.image_size    = size;
    c.announced_crc = ecrc;
    c.image_crc     = icrc;
    c.commit_ok     = cok;
    c.ack_wanted    = ack;
    return c;
  endfunction

  task automatic issue_command(fusc_pkg::cmd_t c);
    int gap;
    gap = quiet_in ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {opcode, ack_wanted, has_notifier, image_size, chunk_sequence, chunk_length,
     announced_crc, image_crc, erase_ok, write_ok, commit_ok} <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
    if (c.opcode != fusc_pkg::OP_IGNORE) commands_sent++;
  endtask

  // dropped opcodes leave nothing to wait for, so allow the pipeline depth on top
  task automatic drain_commands();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_size(logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_size = value;
  endtask

  // one transfer: start, chunks in order with the odd fault, then end unless abandoned
  task automatic run_session();
    logic        ack;
    logic [31:0] size;
    logic [31:0] cap;
    logic [31:0] remaining;
    logic [31:0] len;
    logic [31:0] crc;
    int          r;
    int          chunks;
    ack = ($urandom_range(0, 4) != 0);
    cap = (sb.max_size < 32'd4000) ? sb.max_size : 32'd4000;
    r = $urandom_range(0, 99);
    if (r < 4 || cap == 0) begin
      size = $urandom_range(1, 4000);
    end else if (r < 8 && sb.max_size != 32'hFFFF_FFFF) begin
      size = sb.max_size + 32'd1;
    end else if (r < 10) begin
      size = 32'd0;
    end else if (r < 13) begin
      size = sb.max_size;
    end else begin
      size = $urandom_range(1, cap);
    end
    issue_command(start_cmd(size, $urandom_range(0, 14) != 0, ack));
    chunks = 0;
    while (sb.session_open && sb.bytes_rcvd != sb.target_size && chunks < 30) begin
      remaining = sb.target_size - sb.bytes_rcvd;
      len = $urandom_range(1, 600);
      if (len > remaining) len = remaining;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        issue_command(data_cmd(ack ? sb.next_seq : 16'($urandom()), len[15:0], 1'b1, ack));
      end else if (r < 85) begin
        issue_command(data_cmd(sb.next_seq - 16'd1, len[15:0], 1'b1, ack));
      end else if (r < 88) begin
        issue_command(data_cmd(sb.next_seq + 16'($urandom_range(1, 65534)), len[15:0],
                               1'b1, ack));
      end else if (r < 91) begin
        issue_command(data_cmd(sb.next_seq, 16'd0, 1'b1, ack));
      end else if (r < 94) begin
        len = (remaining < 32'd65535) ? remaining + 32'd1 : 32'd65535;
        issue_command(data_cmd(sb.next_seq, len[15:0], 1'b1, ack));
      end else if (r < 97) begin
        issue_command(data_cmd(sb.next_seq, len[15:0], 1'b0, ack));
      end else begin
        issue_command(random_cmd());
      end
      chunks++;
    end
    r = $urandom_range(0, 99);
    if (r < 8) return;  // abandoned transfer
    crc = $urandom();
    size = sb.target_size;
    if (r < 14) size = size ^ (32'd1 << $urandom_range(0, 31));
    issue_command(end_cmd(size, crc,
                          ($urandom_range(0, 9) == 0) ? crc ^ (32'd1 << $urandom_range(0, 31))
                                                      : crc,
                          $urandom_range(0, 9) != 0, ack));
  endtask

  task automatic directed_checks();
    fusc_pkg::cmd_t c;
    issue_command(data_cmd(16'h0000, 16'd8, 1'b1, 1'b1));
    issue_command(end_cmd(32'd8, 32'h1, 32'h1, 1'b1, 1'b1));
    c = random_cmd();
    c.opcode = fusc_pkg::OP_IGNORE;
    issue_command(c);
    issue_command(start_cmd(32'd0, 1'b1, 1'b1));
    issue_command(start_cmd(32'hFFFF_FFFF, 1'b1, 1'b1));
    issue_command(start_cmd(fusc_pkg::MaxImageSizeReset + 32'd1, 1'b1, 1'b1));
    issue_command(start_cmd(fusc_pkg::MaxImageSizeReset, 1'b0, 1'b1));
    issue_command(start_cmd(32'd100, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0000, 16'd0, 1'b1, 1'b1));
    // sequence zero expected, so ffff is out of order rather than a repeat
    issue_command(data_cmd(16'hFFFF, 16'd10, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0000, 16'd40, 1'b0, 1'b1));
    issue_command(data_cmd(16'h0000, 16'd40, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0000, 16'd40, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0005, 16'd10, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0001, 16'd61, 1'b1, 1'b1));
    issue_command(end_cmd(32'd100, 32'h0, 32'h0, 1'b1, 1'b1));
    issue_command(data_cmd(16'h0001, 16'd60, 1'b1, 1'b1));
    issue_command(end_cmd(32'd99, 32'h0, 32'h0, 1'b1, 1'b1));
    issue_command(end_cmd(32'd100, 32'h1234_5678, 32'h1234_5679, 1'b1, 1'b1));
    issue_command(end_cmd(32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    issue_command(end_cmd(32'd100, 32'h8000_0001, 32'h8000_0001, 1'b1, 1'b1));
    // session without acknowledges: no sequence checks
    issue_command(start_cmd(fusc_pkg::MaxImageSizeReset, 1'b1, 1'b0));
    issue_command(data_cmd(16'hFFFF, 16'd0, 1'b1, 1'b0));
    issue_command(data_cmd(16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    issue_command(end_cmd(fusc_pkg::MaxImageSizeReset, 32'h0, 32'h0, 1'b1, 1'b0));
  endtask

  initial begin : stimulus
    logic [31:0] size_settings[5];
    int          phase_budget[5];
    int          phase_start;
    size_settings = '{32'd0, 32'd1, 32'd5000, 32'hFFFF_FFFF, fusc_pkg::MaxImageSizeReset};
    phase_budget  = '{40, 100, 150, 150, 160};
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    {opcode, ack_wanted, has_notifier, image_size, chunk_sequence, chunk_length,
     announced_crc, image_crc, erase_ok, write_ok, commit_ok} <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();

    for (int i = 0; i < 5; i++) begin
      drain_commands();
      write_max_size(size_settings[i]);
      quiet_in  = (i == 2);
      quiet_out = (i == 2);
      phase_start = commands_sent;
      if (i == 3) begin
        // hold the reply side off while beats keep coming, so the input backs up
        quiet_in  = 1'b1;
        long_hold = 1'b1;
        while (commands_sent - phase_start < 20) begin
          issue_command(data_cmd(sb.next_seq, 16'd1, 1'b1, 1'b1));
        end
        quiet_in = 1'b0;
      end
      while (commands_sent - phase_start < phase_budget[i]) begin
        if ($urandom_range(0, 9) < 8) begin
          run_session();
        end else begin
          issue_command(random_cmd());
        end
      end
    end

    drain_commands();
    repeat (6) @(posedge clk);
    if (sb.pending_replies.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d replies never arrived, expected %0h, actual none",
               $time, sb.pending_replies.size(), sb.pending_replies[0]);
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ firmware_update_session_checker_top.f @@
rtl/fusc_pkg.sv
rtl/fusc_session.sv
rtl/fusc_out_reg.sv
rtl/firmware_update_session_checker_top.sv
dv/tb.sv
